@@ hw/rtl/qhsm_pkg.sv @@
// Shared constants and types for the 2-gram Horspool string matcher.
`timescale 1ns / 1ps

package qhsm_pkg;

    localparam int MAX_PATTERN   = 16;
    localparam int POSITION_BITS = 24;
    localparam int LEN_BITS      = 5;
    localparam int IDX_BITS      = $clog2(MAX_PATTERN);
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 64;

    localparam logic [CFG_IDX_BITS-1:0] REG_PATTERN_LOW  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_PATTERN_HIGH = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_PATTERN_LEN  = 2'd2;

    localparam logic [LEN_BITS-1:0] LEN_RESET = 5'd1;
    localparam logic [LEN_BITS-1:0] LEN_MAX   = LEN_BITS'(MAX_PATTERN);

    typedef logic [7:0]               byte_t;
    typedef logic [POSITION_BITS-1:0] pos_t;

    localparam pos_t POS_MAX = '1;

    typedef struct packed {
        logic [MAX_PATTERN-1:0][7:0] aligned;
        logic [MAX_PATTERN-1:0]      mask;
        logic [LEN_BITS-1:0]         length;
        logic                        enabled;
    } qhsm_cfg_t;

    typedef struct packed {
        logic found;
        pos_t start;
        pos_t total;
        logic done;
    } qhsm_result_t;

endpackage

@@ hw/rtl/qhsm_cfg.sv @@
// Pattern registers and alignment of pattern bytes against the window.
`timescale 1ns / 1ps

module qhsm_cfg
    import qhsm_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     wr_en,
    input  logic [CFG_IDX_BITS-1:0]  wr_index,
    input  logic [CFG_DATA_BITS-1:0] wr_data,
    output qhsm_cfg_t                cfg
);

    logic [CFG_DATA_BITS-1:0] low_reg;
    logic [CFG_DATA_BITS-1:0] high_reg;
    logic [LEN_BITS-1:0]      len_reg;
    logic [MAX_PATTERN-1:0][7:0] pattern;
    logic [LEN_BITS-1:0]      len_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg  <= '0;
            high_reg <= '0;
            len_reg  <= LEN_RESET;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_PATTERN_LOW:  low_reg  <= wr_data;
                REG_PATTERN_HIGH: high_reg <= wr_data;
                REG_PATTERN_LEN:  len_reg  <= wr_data[LEN_BITS-1:0];
                default:          ;
            endcase
        end
    end

    assign pattern = {high_reg, low_reg};
    assign len_eff = (len_reg > LEN_MAX) ? LEN_MAX : len_reg;

    always_comb
    begin
        cfg.length  = len_eff;
        cfg.enabled = (len_eff != '0);
        for (int k = 0; k < MAX_PATTERN; k++)
        begin
            cfg.mask[k]    = (LEN_BITS'(k) < len_eff);
            cfg.aligned[k] = pattern[IDX_BITS'(len_eff - LEN_BITS'(1) - LEN_BITS'(k))];
        end
    end

endmodule

@@ hw/rtl/qhsm_core.sv @@
// Byte window, position and match count with the parallel window compare.
`timescale 1ns / 1ps

module qhsm_core
    import qhsm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         advance,
    input  byte_t        text_byte,
    input  logic         final_byte,
    input  qhsm_cfg_t    cfg,
    output qhsm_result_t result
);

    byte_t [MAX_PATTERN-1:0] window_reg;
    byte_t [MAX_PATTERN-1:0] window_next;
    pos_t                    pos_reg;
    pos_t                    pos_next;
    pos_t                    count_reg;
    pos_t                    count_next;
    logic [MAX_PATTERN-1:0]  lane_ok;
    logic                    hit;

    always_comb
    begin
        window_next[0] = text_byte;
        for (int k = 1; k < MAX_PATTERN; k++)
        begin
            window_next[k] = window_reg[k-1];
        end
        for (int k = 0; k < MAX_PATTERN; k++)
        begin
            lane_ok[k] = !cfg.mask[k] || (window_next[k] == cfg.aligned[k]);
        end
    end

    assign pos_next   = (pos_reg != POS_MAX) ? pos_reg + pos_t'(1) : pos_reg;
    assign hit        = cfg.enabled && (pos_next >= pos_t'(cfg.length)) && (&lane_ok);
    assign count_next = (hit && count_reg != POS_MAX) ? count_reg + pos_t'(1) : count_reg;

    assign result.found = hit;
    assign result.start = hit ? pos_next - pos_t'(cfg.length) : '0;
    assign result.total = count_next;
    assign result.done  = final_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            pos_reg    <= '0;
            count_reg  <= '0;
        end
        else if (advance)
        begin
            if (final_byte)
            begin
                window_reg <= '0;
                pos_reg    <= '0;
                count_reg  <= '0;
            end
            else
            begin
                window_reg <= window_next;
                pos_reg    <= pos_next;
                count_reg  <= count_next;
            end
        end
    end

endmodule

@@ hw/rtl/qgram_horspool_string_matcher_top.sv @@
// Top level of the streaming 2-gram Horspool string matcher.
//
//   channel   | direction | payload
//   s_axis    | in        | tdata[7:0] text byte, tlast final byte
//   m_axis    | out       | tdata[23:0] start, tdata[47:24] total, tuser found, tlast done
//   cfg       | in        | cfg_index register, cfg_data value
//
// One byte per cycle while the output is not stalled; results come from the output register.
// The input register feeds the window compare, which writes the output register.
// Reset clears window, position, count and both valid flags; pattern length resets to 1.
// A stalled output holds; the input register still takes one request behind it.
`timescale 1ns / 1ps

module qgram_horspool_string_matcher_top
    import qhsm_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [7:0]               s_axis_tdata,   // [7:0] text_byte
    input  logic                     s_axis_tlast,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [47:0]              m_axis_tdata,   // [23:0] match_start, [47:24] match_total
    output logic                     m_axis_tuser,   // [0] match_found
    output logic                     m_axis_tlast,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    logic         in_valid_reg;
    byte_t        in_byte_reg;
    logic         in_last_reg;
    logic         out_valid_reg;
    qhsm_result_t out_reg;
    qhsm_result_t result;
    qhsm_cfg_t    cfg;
    logic         advance;
    logic         take;

    assign cfg_ready     = 1'b1;
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign take          = s_axis_tvalid && s_axis_tready;

    qhsm_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    qhsm_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .text_byte  (in_byte_reg),
        .final_byte (in_last_reg),
        .cfg        (cfg),
        .result     (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
        if (advance)
        begin
            out_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_reg.total, out_reg.start};
    assign m_axis_tuser  = out_reg.found;
    assign m_axis_tlast  = out_reg.done;

endmodule

@@ hw/rtl/qhsm_checker.sv @@
// Port-level assertions for the string matcher top level.
`timescale 1ns / 1ps

module qhsm_checker
    import qhsm_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     s_axis_tready,
    input logic                     m_axis_tvalid,
    input logic                     m_axis_tready,
    input logic [47:0]              m_axis_tdata,
    input logic                     m_axis_tuser,
    input logic                     m_axis_tlast
);

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    a_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[23:0] == 24'd0)
        else $error("start set without a match");

    a_total_counts: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[47:24] != 24'd0)
        else $error("match reported with zero total");

    a_ready_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with empty output");

endmodule

bind qgram_horspool_string_matcher_top qhsm_checker u_qhsm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

@@ tb/tb_qgram_horspool_string_matcher_top.sv @@
// Self-checking testbench for the streaming 2-gram Horspool string matcher.
`timescale 1ns / 1ps

module tb_qgram_horspool_string_matcher_top;
    import qhsm_pkg::*;

    localparam int RANDOM_BYTES   = 800;
    localparam int SETTLE_CYCLES  = 4;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PLAN_ROWS      = 24;

    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = 2'd3;

    typedef enum logic {ROW_WRITE, ROW_BYTE} row_kind_e;

    typedef struct packed {
        row_kind_e                 kind;
        logic [CFG_IDX_BITS-1:0]   index;
        logic [CFG_DATA_BITS-1:0]  value;
        byte_t                     text;
        logic                      last;
        logic                      typed;
        qhsm_result_t              want;
    } plan_row_t;

    localparam plan_row_t PLAN [PLAN_ROWS] = '{
        '{ROW_BYTE,  REG_PATTERN_LOW,  64'h0,    8'h00, 1'b0, 1'b1, '{1'b1, 24'd0, 24'd1, 1'b0}},
        '{ROW_BYTE,  REG_PATTERN_LOW,  64'h0,    8'hFF, 1'b1, 1'b1, '{1'b0, 24'd0, 24'd1, 1'b1}},
        '{ROW_WRITE, REG_PATTERN_LOW,  64'h4241, 8'h00, 1'b0, 1'b0, '0},
        '{ROW_WRITE, REG_PATTERN_LEN,  64'd2,    8'h00, 1'b0, 1'b0, '0},
        '{ROW_BYTE,  REG_PATTERN_LOW,  64'h0,    8'h41, 1'b0, 1'b1, '{1'b0, 24'd0, 24'd0, 1'b0}},
        '{ROW_BYTE,  REG_PATTERN_LOW,  64'h0,    8'h42, 1'b0, 1'b1, '{1'b1, 24'd0, 24'd1, 1'b0}},
        '{ROW_BYTE,  REG_PATTERN_LOW,  64'h0,    8'h41, 1'b0, 1'b0, '0},
        '{ROW_BYTE,  REG_PATTERN_LOW,  64'h0,    8'h42, 1'b1, 1'b1, '{1'b1, 24'd2, 24'd2, 1'b1}},
        '{ROW_BYTE,  REG_PATTERN_LOW,  64'h0,    8'h41, 1'b1, 1'b1, '{1'b0, 24'd0, 24'd0, 1'b1}},
        '{ROW_BYTE,  REG_PATTERN_LOW,  64'h0,    8'h42, 1'b1, 1'b1, '{1'b0, 24'd0, 24'd0, 1'b1}},
        '{ROW_WRITE, REG_PATTERN_LOW,  64'h0,    8'h00, 1'b0, 1'b0, '0},
        '{ROW_WRITE, REG_PATTERN_LEN,  64'd3,    8'h00, 1'b0, 1'b0, '0},
        '{ROW_BYTE,  REG_PATTERN_LOW,  64'h0,    8'h00, 1'b0, 1'b1, '{1'b0, 24'd0, 24'd0, 1'b0}},
        '{ROW_BYTE,  REG_PATTERN_LOW,  64'h0,    8'h00, 1'b1, 1'b1, '{1'b0, 24'd0, 24'd0, 1'b1}},
        '{ROW_BYTE,  REG_PATTERN_LOW,  64'h0,    8'h00, 1'b0, 1'b0, '0},
        '{ROW_BYTE,  REG_PATTERN_LOW,  64'h0,    8'h00, 1'b0, 1'b0, '0},
        '{ROW_BYTE,  REG_PATTERN_LOW,  64'h0,    8'h00, 1'b0, 1'b1, '{1'b1, 24'd0, 24'd1, 1'b0}},
        '{ROW_BYTE,  REG_PATTERN_LOW,  64'h0,    8'h00, 1'b1, 1'b1, '{1'b1, 24'd1, 24'd2, 1'b1}},
        '{ROW_WRITE, REG_PATTERN_LEN,  64'd0,    8'h00, 1'b0, 1'b0, '0},
        '{ROW_BYTE,  REG_PATTERN_LOW,  64'h0,    8'h00, 1'b0, 1'b1, '{1'b0, 24'd0, 24'd0, 1'b0}},
        '{ROW_BYTE,  REG_PATTERN_LOW,  64'h0,    8'hFF, 1'b1, 1'b1, '{1'b0, 24'd0, 24'd0, 1'b1}},
        '{ROW_WRITE, REG_PATTERN_LEN,  64'hFFFF_FFFF_FFFF_FFF1, 8'h00, 1'b0, 1'b0, '0},
        '{ROW_WRITE, REG_PATTERN_HIGH, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, '0},
        '{ROW_BYTE,  REG_PATTERN_LOW,  64'h0,    8'hFF, 1'b1, 1'b1, '{1'b0, 24'd0, 24'd0, 1'b1}}
    };

    logic                     clk;
    logic                     rst_n         = 1'b0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [7:0]               s_axis_tdata  = '0;
    logic                     s_axis_tlast  = 1'b0;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [47:0]              m_axis_tdata;
    logic                     m_axis_tuser;
    logic                     m_axis_tlast;
    logic                     cfg_valid     = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index     = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data      = '0;

    logic [CFG_DATA_BITS-1:0] pattern_low  = '0;
    logic [CFG_DATA_BITS-1:0] pattern_high = '0;
    logic [LEN_BITS-1:0]      pattern_len  = LEN_RESET;
    byte_t                    recent_bytes [MAX_PATTERN];
    pos_t                     text_pos;
    pos_t                     hit_count;

    qhsm_result_t expected_results [$];
    logic         source_quiet = 1'b0;
    int unsigned  bytes_sent = 0;
    int unsigned  results_seen = 0;
    int unsigned  matches_seen = 0;
    int unsigned  texts_done = 0;
    int unsigned  register_writes = 0;
    int unsigned  pattern_settings = 0;
    int unsigned  mismatches = 0;
    int unsigned  idle_cycles = 0;

    qgram_horspool_string_matcher_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int unsigned idle_len();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic byte_t pattern_byte(input int idx);
        if (idx < 8)
            return pattern_low[8*idx +: 8];
        return pattern_high[8*(idx-8) +: 8];
    endfunction

    function automatic void clear_text_state();
        foreach (recent_bytes[k])
            recent_bytes[k] = '0;
        text_pos  = '0;
        hit_count = '0;
    endfunction

    function automatic int active_span();
        return (pattern_len > LEN_MAX) ? MAX_PATTERN : int'(pattern_len);
    endfunction

    function automatic qhsm_result_t scan_byte(input byte_t text, input logic last);
        qhsm_result_t r;
        int           span;
        r    = '0;
        span = active_span();
        for (int k = MAX_PATTERN - 1; k > 0; k--)
            recent_bytes[k] = recent_bytes[k-1];
        recent_bytes[0] = text;
        if (text_pos != POS_MAX)
            text_pos++;
        if (span >= 1 && text_pos >= pos_t'(span))
        begin
            r.found = 1'b1;
            for (int k = 0; k < span; k++)
                if (recent_bytes[k] != pattern_byte(span - 1 - k))
                    r.found = 1'b0;
            if (r.found)
            begin
                r.start = text_pos - pos_t'(span);
                if (hit_count != POS_MAX)
                    hit_count++;
            end
        end
        r.total = hit_count;
        r.done  = last;
        if (last)
            clear_text_state();
        return r;
    endfunction

    task automatic push_byte(input byte_t text, input logic last, input logic typed,
                             input qhsm_result_t want);
        int unsigned  gap;
        qhsm_result_t predicted;
        gap = source_quiet ? 0 : idle_len();
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= text;
        s_axis_tlast  <= last;
        do @(posedge clk); while (!s_axis_tready);
        predicted = scan_byte(text, last);
        expected_results.push_back(typed ? want : predicted);
        bytes_sent++;
    endtask

    task automatic feed_random(input byte_t text);
        push_byte(text, $urandom_range(0, 29) == 0, 1'b0, '0);
    endtask

    task automatic write_register(input logic [CFG_IDX_BITS-1:0] index,
                                  input logic [CFG_DATA_BITS-1:0] value);
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (index)
            REG_PATTERN_LOW:  pattern_low  = value;
            REG_PATTERN_HIGH: pattern_high = value;
            REG_PATTERN_LEN:  pattern_len  = value[LEN_BITS-1:0];
            default:          ;
        endcase
        register_writes++;
    endtask

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    initial
    begin
        int unsigned               stall;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(40, 160)) @(posedge clk);
            end
            else
            begin
                stall = idle_len();
                if (stall != 0)
                begin
                    m_axis_tready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        qhsm_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (m_axis_tuser)
                matches_seen++;
            if (m_axis_tlast)
                texts_done++;
            if (expected_results.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result, found %0b start %0d total %0d done %0b",
                         $time, m_axis_tuser, m_axis_tdata[23:0], m_axis_tdata[47:24],
                         m_axis_tlast);
            end
            else
            begin
                want = expected_results.pop_front();
                compare_field("match_found", 32'(want.found), 32'(m_axis_tuser));
                compare_field("match_start", 32'(want.start), 32'(m_axis_tdata[23:0]));
                compare_field("match_total", 32'(want.total), 32'(m_axis_tdata[47:24]));
                compare_field("text_done", 32'(want.done), 32'(m_axis_tlast));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no request accepted for %0d cycles, %0d results outstanding",
                         $time, idle_cycles, expected_results.size());
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial
    begin
        int unsigned              target;
        int unsigned              span;
        int unsigned              broken_at;
        int unsigned              len_pick;
        logic                     narrow;
        logic                     first_phase;
        logic                     broken;
        byte_t                    alpha [2];
        logic [2*CFG_DATA_BITS-1:0] pattern_bits;
        logic [CFG_DATA_BITS-1:0] noise64;
        byte_t                    b;

        clear_text_state();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < PLAN_ROWS; r++)
        begin
            if (PLAN[r].kind == ROW_WRITE)
                write_register(PLAN[r].index, PLAN[r].value);
            else
                push_byte(PLAN[r].text, PLAN[r].last, PLAN[r].typed, PLAN[r].want);
        end
        pattern_settings = 5;

        first_phase = 1'b1;
        target = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < target)
        begin
            narrow       = 1'($urandom_range(0, 1));
            source_quiet = ($urandom_range(0, 4) == 0);
            alpha[0]     = byte_t'($urandom_range(0, 255));
            alpha[1]     = byte_t'($urandom_range(0, 255));
            for (int i = 0; i < 2 * MAX_PATTERN / 2 * 1; i++)
                pattern_bits[8*i +: 8] = narrow ? alpha[1'($urandom_range(0, 1))]
                                                : byte_t'($urandom_range(0, 255));
            len_pick = $urandom_range(0, 19);
            if (len_pick == 0)
                span = 0;
            else if (len_pick < 4)
                span = MAX_PATTERN;
            else if (len_pick == 4)
                span = $urandom_range(MAX_PATTERN + 1, 31);
            else
                span = $urandom_range(1, MAX_PATTERN);

            if (first_phase)
                write_register(REG_SPARE, {$urandom, $urandom});
            if (first_phase || $urandom_range(0, 3) != 0)
                write_register(REG_PATTERN_LOW, pattern_bits[CFG_DATA_BITS-1:0]);
            if (first_phase || $urandom_range(0, 3) != 0)
                write_register(REG_PATTERN_HIGH, pattern_bits[2*CFG_DATA_BITS-1:CFG_DATA_BITS]);
            noise64 = {$urandom, $urandom};
            write_register(REG_PATTERN_LEN, {noise64[CFG_DATA_BITS-1:LEN_BITS], LEN_BITS'(span)});
            pattern_settings++;
            first_phase = 1'b0;

            span = active_span();
            repeat ($urandom_range(4, 16))
            begin
                if (span != 0 && $urandom_range(0, 9) < 6)
                begin
                    broken    = ($urandom_range(0, 4) == 0);
                    broken_at = $urandom_range(0, span - 1);
                    for (int i = 0; i < span; i++)
                    begin
                        b = pattern_byte(i);
                        if (broken && i == broken_at)
                            b = byte_t'($urandom_range(0, 255));
                        feed_random(b);
                    end
                end
                else
                begin
                    repeat ($urandom_range(1, 6))
                        feed_random(narrow && $urandom_range(0, 3) != 0
                                    ? alpha[1'($urandom_range(0, 1))]
                                    : byte_t'($urandom_range(0, 255)));
                end
            end
            if ($urandom_range(0, 1) == 0)
                push_byte(byte_t'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
        end

        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d text bytes in %0d finished texts, %0d of %0d results matched",
                 bytes_sent, texts_done, matches_seen, results_seen);
        $display("%0d register writes over %0d pattern settings, %0d field mismatches",
                 register_writes, pattern_settings, mismatches);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/qhsm_pkg.sv
hw/rtl/qhsm_cfg.sv
hw/rtl/qhsm_core.sv
hw/rtl/qgram_horspool_string_matcher_top.sv
hw/rtl/qhsm_checker.sv
tb/tb_qgram_horspool_string_matcher_top.sv
